// ----- src/wsts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wsts_pkg;

  localparam int NumWorkersDef = 8;
  localparam int QueueDepthDef = 64;
  localparam int TaskBitsDef   = 16;

  localparam int TaskIdW    = 16;
  localparam int WorkerIdW  = 3;
  localparam int StatusW    = 3;
  localparam int QueueUsedW = 3;
  localparam int CfgW       = 4;

  localparam logic [CfgW-1:0] WorkersInUseRst = 4'd4;

  typedef enum logic [StatusW-1:0] {
    ST_QUEUED  = 3'd0,
    ST_DROPPED = 3'd1,
    ST_OWN     = 3'd2,
    ST_STOLEN  = 3'd3,
    ST_NONE    = 3'd4
  } status_e;

  // request held by the top level while the queue logic works on it
  typedef struct packed {
    logic                 fire;
    logic                 fetch;
    logic [WorkerIdW-1:0] worker;
  } exec_t;

  typedef struct packed {
    status_e               status;
    logic [QueueUsedW-1:0] queue;
  } res_t;

endpackage

`default_nettype wire

// ----- src/wsts_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsts_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/wsts_queue_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsts_queue_ctrl #(
  parameter int NumWorkers = wsts_pkg::NumWorkersDef,
  parameter int QueueDepth = wsts_pkg::QueueDepthDef,
  localparam int QW   = (NumWorkers > 1) ? $clog2(NumWorkers) : 1,
  localparam int FW   = $clog2(QueueDepth),
  localparam int CntW = $clog2(QueueDepth + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire wsts_pkg::exec_t             exec_i,
  input  wire logic [wsts_pkg::CfgW-1:0]   workers_in_use_i,
  output logic                             ram_we_o,
  output logic                             ram_re_o,
  output logic      [QW+FW-1:0]            ram_addr_o,
  output wsts_pkg::res_t                   res_o
);

  logic [FW-1:0]   front_q [NumWorkers];
  logic [FW-1:0]   front_d [NumWorkers];
  logic [CntW-1:0] cnt_q   [NumWorkers];
  logic [CntW-1:0] cnt_d   [NumWorkers];
  logic [QW-1:0]   sc_q, sc_d;

  logic [wsts_pkg::CfgW-1:0] n_act;
  logic [QW-1:0]   sub_q, widx, hi_idx, lo_idx, pick;
  logic            full, w_act, own, hi_hit, lo_hit, steal;
  logic [FW:0]     back_sum, back_slot;
  logic [FW-1:0]   slot;
  logic            we, re;

  always_comb begin
    if (workers_in_use_i == '0) begin
      n_act = wsts_pkg::CfgW'(1);
    end else if (int'(workers_in_use_i) > NumWorkers) begin
      n_act = wsts_pkg::CfgW'(NumWorkers);
    end else begin
      n_act = workers_in_use_i;
    end
  end

  // circular scan: lowest non-empty queue at or above the worker, else lowest overall
  always_comb begin
    hi_hit = 1'b0;
    lo_hit = 1'b0;
    hi_idx = '0;
    lo_idx = '0;
    for (int j = NumWorkers - 1; j >= 0; j--) begin
      if (cnt_q[j] != '0 && j < int'(n_act)) begin
        lo_hit = 1'b1;
        lo_idx = QW'(j);
        if (j >= int'(exec_i.worker)) begin
          hi_hit = 1'b1;
          hi_idx = QW'(j);
        end
      end
    end
  end

  always_comb begin
    sub_q = (int'(sc_q) < int'(n_act)) ? sc_q : '0;
    sc_d  = (int'(sub_q) + 1 >= int'(n_act)) ? '0 : sub_q + QW'(1);
    full  = cnt_q[sub_q] == CntW'(QueueDepth);

    widx  = QW'(exec_i.worker);
    w_act = int'(exec_i.worker) < int'(n_act);
    own   = w_act && (cnt_q[widx] != '0);
    steal = w_act && !own && lo_hit;
    pick  = hi_hit ? hi_idx : lo_idx;

    back_sum  = {1'b0, front_q[pick]} + (FW+1)'(cnt_q[pick] - CntW'(1));
    back_slot = (int'(back_sum) >= QueueDepth) ? back_sum - (FW+1)'(QueueDepth) : back_sum;

    front_d = front_q;
    cnt_d   = cnt_q;
    we      = 1'b0;
    re      = 1'b0;
    slot    = '0;
    res_o.status = wsts_pkg::ST_NONE;
    res_o.queue  = '0;
    ram_addr_o   = '0;

    if (!exec_i.fetch) begin
      res_o.queue = wsts_pkg::QueueUsedW'(sub_q);
      if (full) begin
        res_o.status = wsts_pkg::ST_DROPPED;
      end else begin
        res_o.status = wsts_pkg::ST_QUEUED;
        slot = (front_q[sub_q] == '0) ? FW'(QueueDepth - 1) : front_q[sub_q] - FW'(1);
        front_d[sub_q] = slot;
        cnt_d[sub_q]   = cnt_q[sub_q] + CntW'(1);
        we = 1'b1;
      end
      ram_addr_o = {sub_q, slot};
    end else if (own) begin
      res_o.status = wsts_pkg::ST_OWN;
      res_o.queue  = wsts_pkg::QueueUsedW'(widx);
      slot = front_q[widx];
      front_d[widx] = (front_q[widx] == FW'(QueueDepth - 1)) ? '0 : front_q[widx] + FW'(1);
      cnt_d[widx]   = cnt_q[widx] - CntW'(1);
      re = 1'b1;
      ram_addr_o = {widx, slot};
    end else if (steal) begin
      res_o.status = wsts_pkg::ST_STOLEN;
      res_o.queue  = wsts_pkg::QueueUsedW'(pick);
      slot = back_slot[FW-1:0];
      cnt_d[pick] = cnt_q[pick] - CntW'(1);
      re = 1'b1;
      ram_addr_o = {pick, slot};
    end
  end

  assign ram_we_o = exec_i.fire && we;
  assign ram_re_o = exec_i.fire && re;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
      for (int j = 0; j < NumWorkers; j++) begin
        front_q[j] <= '0;
        cnt_q[j]   <= '0;
      end
    end else if (exec_i.fire) begin
      if (!exec_i.fetch) begin
        sc_q <= sc_d;
      end
      front_q <= front_d;
      cnt_q   <= cnt_d;
    end
  end

  a_one_port_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("task store written and read in the same cycle");

  a_queued_writes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i.fire && !exec_i.fetch && res_o.status == wsts_pkg::ST_QUEUED |-> ram_we_o)
    else $error("queued item without a task store write");

  a_grant_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i.fire && (res_o.status == wsts_pkg::ST_OWN || res_o.status == wsts_pkg::ST_STOLEN)
    |=> cnt_q[$past(pick)] != CntW'(QueueDepth) && !$past(ram_we_o))
    else $error("grant taken from a full queue or with a write");

endmodule

`default_nettype wire

// ----- src/work_stealing_task_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Work-stealing scheduler: one double-ended task queue per worker, all held in a
// single-port task store (NUM_WORKERS regions of QUEUE_DEPTH rounded up to a power
// of two). A submit (req_type 0) pushes task_id onto the front of the queue picked
// by a round-robin counter; a fetch (req_type 1) pops the front of the worker's own
// queue or steals from the back of the next non-empty queue in circular order.
// Every item gives exactly one result. An item passes through S_EXEC, for queue
// selection and the task store access, then S_FIN, for the registered store read,
// during which the next item is accepted if the output is free. A stalled output
// holds the block in S_FIN. workers_in_use is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, which the block itself does
// not enforce. 0 acts as 1 and values above NUM_WORKERS act as NUM_WORKERS.
module work_stealing_task_scheduler #(
  parameter int NUM_WORKERS = wsts_pkg::NumWorkersDef,
  parameter int QUEUE_DEPTH = wsts_pkg::QueueDepthDef,
  parameter int TASK_BITS   = wsts_pkg::TaskBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [wsts_pkg::CfgW-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            req_type_i,
  input  wire logic [wsts_pkg::TaskIdW-1:0]    task_id_i,
  input  wire logic [wsts_pkg::WorkerIdW-1:0]  worker_id_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [wsts_pkg::StatusW-1:0]    status_o,
  output logic      [wsts_pkg::TaskIdW-1:0]    granted_task_o,
  output logic      [wsts_pkg::QueueUsedW-1:0] queue_used_o
);

  localparam int QW      = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int FW      = $clog2(QUEUE_DEPTH);
  localparam int TaskIdW = wsts_pkg::TaskIdW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [wsts_pkg::CfgW-1:0]      wiu_q;
  logic                           req_type_q;
  logic [TaskIdW-1:0]             task_q;
  logic [wsts_pkg::WorkerIdW-1:0] worker_q;
  wsts_pkg::res_t                 res, res_q;
  wsts_pkg::exec_t                exec;

  logic                           out_valid_q;
  logic [wsts_pkg::StatusW-1:0]   status_q;
  logic [TaskIdW-1:0]             granted_q;
  logic [wsts_pkg::QueueUsedW-1:0] used_q;

  logic                 ram_we, ram_re;
  logic [QW+FW-1:0]     ram_addr;
  logic [TASK_BITS-1:0] ram_rdata;
  logic                 out_free, in_acc, load_out;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || (state_q == S_FIN && out_free);
  assign in_acc   = in_valid_i && in_ready_o;
  assign load_out = (state_q == S_FIN) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = in_acc ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign exec.fire   = (state_q == S_EXEC);
  assign exec.fetch  = req_type_q;
  assign exec.worker = worker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wiu_q       <= wsts_pkg::WorkersInUseRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        wiu_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_type_q <= req_type_i;
      task_q     <= task_id_i;
      worker_q   <= worker_id_i;
    end
    if (state_q == S_EXEC) begin
      res_q <= res;
    end
    if (load_out) begin
      status_q <= res_q.status;
      used_q   <= res_q.queue;
      // the registered store read holds the data from the access made in S_EXEC
      if (res_q.status == wsts_pkg::ST_OWN || res_q.status == wsts_pkg::ST_STOLEN) begin
        granted_q <= TaskIdW'(ram_rdata);
      end else begin
        granted_q <= '0;
      end
    end
  end

  wsts_queue_ctrl #(
    .NumWorkers (NUM_WORKERS),
    .QueueDepth (QUEUE_DEPTH)
  ) u_queue_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .exec_i           (exec),
    .workers_in_use_i (wiu_q),
    .ram_we_o         (ram_we),
    .ram_re_o         (ram_re),
    .ram_addr_o       (ram_addr),
    .res_o            (res)
  );

  wsts_ram #(
    .Width (TASK_BITS),
    .Depth (2 ** (QW + FW))
  ) u_task_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (TASK_BITS'(task_q)),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign granted_task_o = granted_q;
  assign queue_used_o   = used_q;

  a_exec_then_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_FIN)
    else $error("queue step not followed by result stage");

  a_result_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FIN))
    else $error("result shown without a finished item");

  a_no_grant_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != wsts_pkg::ST_OWN && status_o != wsts_pkg::ST_STOLEN
    |-> granted_task_o == '0)
    else $error("task id given without a grant");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int NumQueues  = wsts_pkg::NumWorkersDef;
  localparam int QueueSlots = wsts_pkg::QueueDepthDef;
  localparam int StallLimit = 2000;
  localparam int TaskIdW    = wsts_pkg::TaskIdW;
  localparam int WorkerIdW  = wsts_pkg::WorkerIdW;
  localparam int StatusW    = wsts_pkg::StatusW;
  localparam int QueueUsedW = wsts_pkg::QueueUsedW;
  localparam int CfgW       = wsts_pkg::CfgW;

  typedef struct packed {
    wsts_pkg::status_e     status;
    logic [TaskIdW-1:0]    tid;
    logic [QueueUsedW-1:0] queue;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CfgW-1:0]       cfg_wdata;
  logic                  in_valid;
  logic                  in_ready_o;
  logic                  req_type;
  logic [TaskIdW-1:0]    task_id;
  logic [WorkerIdW-1:0]  worker_id;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  logic [StatusW-1:0]    status_o;
  logic [TaskIdW-1:0]    granted_task_o;
  logic [QueueUsedW-1:0] queue_used_o;

  // scheduler state as the block should hold it
  logic [TaskIdW-1:0] slot_mem [NumQueues][QueueSlots];
  logic [5:0]         head [NumQueues];
  int                 fill [NumQueues];
  int                 rr_next;
  logic [CfgW-1:0]    workers_reg;

  reply_t awaited[$];
  int     errors = 0;
  bit     idle_on;
  int     stall_left = 0;
  int     quiet_cycles = 0;

  work_stealing_task_scheduler DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type),
    .task_id_i     (task_id),
    .worker_id_i   (worker_id),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .status_o      (status_o),
    .granted_task_o(granted_task_o),
    .queue_used_o  (queue_used_o)
  );

  always #6 clk = ~clk;

  function automatic reply_t schedule_request(logic fetch, logic [TaskIdW-1:0] tid,
                                              logic [WorkerIdW-1:0] worker);
    reply_t     r;
    int         n;
    int         q;
    int         w;
    int         i;
    logic [5:0] slot;
    n = (workers_reg == 0) ? 1 : (workers_reg > NumQueues) ? NumQueues : int'(workers_reg);
    w = int'(worker);
    r.status = wsts_pkg::ST_NONE;
    r.tid    = '0;
    r.queue  = '0;
    if (!fetch) begin
      // a counter left beyond the active queues falls back to queue 0
      q = (rr_next < n) ? rr_next : 0;
      rr_next = (q + 1 >= n) ? 0 : q + 1;
      r.queue = q[QueueUsedW-1:0];
      if (fill[q] >= QueueSlots) begin
        r.status = wsts_pkg::ST_DROPPED;
      end else begin
        head[q] = head[q] - 6'd1;
        slot_mem[q][head[q]] = tid;
        fill[q]++;
        r.status = wsts_pkg::ST_QUEUED;
      end
    end else if (w < n) begin
      if (fill[w] > 0) begin
        r.tid = slot_mem[w][head[w]];
        head[w] = head[w] + 6'd1;
        fill[w]--;
        r.queue  = worker;
        r.status = wsts_pkg::ST_OWN;
      end else begin
        // steal from the back of the next busy queue in circular order
        for (i = 1; i < n && r.status == wsts_pkg::ST_NONE; i++) begin
          q = (w + i) % n;
          if (fill[q] > 0) begin
            slot = head[q] + 6'(fill[q] - 1);
            fill[q]--;
            r.tid    = slot_mem[q][slot];
            r.queue  = q[QueueUsedW-1:0];
            r.status = wsts_pkg::ST_STOLEN;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic fetch, input logic [TaskIdW-1:0] tid,
                              input logic [WorkerIdW-1:0] worker);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= fetch;
    task_id   <= tid;
    worker_id <= worker;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    awaited.push_back(schedule_request(fetch, tid, worker));
  endtask

  task automatic submit(input logic [TaskIdW-1:0] tid);
    send_request(1'b0, tid, WorkerIdW'($urandom_range(0, 7)));
  endtask

  task automatic fetch_for(input logic [WorkerIdW-1:0] worker);
    send_request(1'b1, TaskIdW'($urandom), worker);
  endtask

  task automatic write_workers(input logic [CfgW-1:0] value);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    // let the read stage of the last item settle
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    workers_reg = value;
  endtask

  task automatic test_empty_fetch();
    fetch_for(3'd0);
    fetch_for(3'd7);
    fetch_for(3'd3);
  endtask

  task automatic test_own_and_steal();
    submit(16'h0000);
    submit(16'hFFFF);
    submit(16'hA5A5);
    submit(16'h5A5A);
    submit(16'h1234);
    fetch_for(3'd0);
    fetch_for(3'd1);
    fetch_for(3'd1);
    fetch_for(3'd3);
    fetch_for(3'd3);
    fetch_for(3'd2);
  endtask

  task automatic test_active_count_range();
    // zero acts as one queue, with the counter left beyond it
    write_workers(4'd0);
    submit(16'hBEEF);
    fetch_for(3'd1);
    fetch_for(3'd0);
    // above the queue count acts as all queues
    write_workers(4'd15);
    repeat (4) submit(TaskIdW'($urandom));
    // queues two and three are left behind
    write_workers(4'd2);
    fetch_for(3'd3);
    fetch_for(3'd0);
    fetch_for(3'd0);
    fetch_for(3'd0);
    write_workers(4'd9);
    fetch_for(3'd7);
  endtask

  task automatic test_random_traffic();
    int               settings [9];
    int               p;
    int               k;
    int               sub_pct;
    logic [TaskIdW-1:0] tid;
    settings = '{1, 8, 3, 0, 15, 2, 5, 8, 6};
    for (p = 0; p < 9; p++) begin
      write_workers(settings[p][CfgW-1:0]);
      idle_on = (p != 8) && (p % 3 != 2);
      for (k = 0; k < 150; k++) begin
        // fill the queues first, then drain them into steals and misses
        sub_pct = (k < 100) ? 88 : 12;
        case ($urandom_range(0, 9))
          0:       tid = '0;
          1:       tid = '1;
          default: tid = TaskIdW'($urandom);
        endcase
        send_request($urandom_range(0, 99) >= sub_pct, tid,
                     WorkerIdW'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    int q;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    req_type  <= 1'b0;
    task_id   <= '0;
    worker_id <= '0;
    idle_on   = 1'b1;
    for (q = 0; q < NumQueues; q++) begin
      head[q] = '0;
      fill[q] = 0;
    end
    rr_next     = 0;
    workers_reg = wsts_pkg::WorkersInUseRst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_fetch();
    test_own_and_steal();
    test_active_count_range();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 15) begin
      stall_left <= int'($urandom_range(1, 12)) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (awaited.size() == 0) begin
        $error("item out with none outstanding: status %0d queue %0d", status_o,
               queue_used_o);
        errors++;
      end else begin
        want = awaited[0];
        awaited.delete(0);
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (granted_task_o !== want.tid) begin
          $error("granted_task: expected %h, got %h", want.tid, granted_task_o);
          errors++;
        end
        if (queue_used_o !== want.queue) begin
          $error("queue_used: expected %0d, got %0d", want.queue, queue_used_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
